@@ rtl/bdp_pkg.sv @@
package bdp_pkg;

   localparam int GLOBAL_BITS  = 13;
   localparam int LOCAL_BITS   = 11;
   localparam int INDEX_BITS   = 11;
   localparam int GLOBAL_DEPTH = 1 << GLOBAL_BITS;
   localparam int LOCAL_DEPTH  = 1 << LOCAL_BITS;
   localparam int INDEX_DEPTH  = 1 << INDEX_BITS;
   localparam int MASK_W       = GLOBAL_BITS;
   localparam int CSR_AW       = 2;
   localparam int CSR_DW       = 4;

   localparam logic [1:0] CTR_MIN      = 2'd0;
   localparam logic [1:0] CTR_MAX      = 2'd3;
   localparam logic [1:0] CTR_RESET    = 2'd1;
   localparam logic [1:0] CHOICE_RESET = 2'd2;

   typedef enum logic [1:0] {
      MODE_STATIC     = 2'd0,
      MODE_GSHARE     = 2'd1,
      MODE_TOURNAMENT = 2'd2,
      MODE_NOT_TAKEN  = 2'd3
   } mode_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_MODE        = 2'd0,
      CSR_GLOBAL_BITS = 2'd1,
      CSR_LOCAL_BITS  = 2'd2,
      CSR_INDEX_BITS  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_HIST  = 2'd2,
      ST_CTR   = 2'd3
   } state_type;

   // zero means one bit, anything above max_bits saturates
   function automatic logic [MASK_W-1:0] width_mask(logic [3:0] bits, logic [4:0] max_bits);
      logic [4:0]        eff;
      logic [MASK_W-1:0] m;
      eff = {1'b0, bits};
      if (eff == 5'd0) begin
         eff = 5'd1;
      end
      if (eff > max_bits) begin
         eff = max_bits;
      end
      for (int i = 0; i < MASK_W; i++) begin
         m[i] = (5'(i) < eff);
      end
      return m;
   endfunction

   function automatic logic [1:0] count_toward(logic [1:0] c, logic up);
      logic [1:0] r;
      if (up) begin
         r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
      end else begin
         r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
      end
      return r;
   endfunction

endpackage

@@ rtl/branch_direction_predictor_core.sv @@
// Branch direction predictor (static taken, not-taken, gshare, tournament).
// After reset the counter, choice and local history memories are swept to
// their initial values, one entry per cycle; no request transfer is taken
// until the sweep is done, while CSR writes are accepted throughout. For each
// request the global, choice and local history memories are read at its
// transfer, then the local counter memory is read at the index given by the
// local history, then the prediction is formed and the counters and histories
// are written back once the output register is free. One request is in
// flight at a time; a new request is taken while the previous result waits in
// the output register.
module branch_direction_predictor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] branch_address, [32] taken_outcome
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] predict_taken
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [3:0]  csr_wdata
);

   localparam int GB = bdp_pkg::GLOBAL_BITS;
   localparam int LB = bdp_pkg::LOCAL_BITS;
   localparam int IB = bdp_pkg::INDEX_BITS;

   bdp_pkg::state_type state_ff, state_in;
   bdp_pkg::mode_type  mode_ff;
   logic [3:0]         gbits_ff, lbits_ff, abits_ff;

   logic [GB-1:0] clr_ff, clr_in;
   logic [GB-1:0] ghist_ff, ghist_in;
   logic [GB-1:0] gidx_ff;
   logic [IB-1:0] aidx_ff;
   logic [LB-1:0] lidx_ff;
   logic          train_ff, outcome_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_pred_ff;

   logic [GB-1:0] gmask, ghist_m, gidx_acc;
   logic [LB-1:0] lmask, lidx_hist;
   logic [IB-1:0] amask, aidx_acc;
   logic [31:0]   pc;
   logic          accept, commit, clearing;
   logic          gpred, lpred, pred, do_gs, do_tn;

   logic [1:0]    gctr_rd, choice_rd, lctr_rd;
   logic [LB-1:0] lhist_rd;

   logic          gctr_we, choice_we, lctr_we, lhist_we;
   logic [GB-1:0] g_waddr;
   logic [LB-1:0] l_waddr;
   logic [IB-1:0] h_waddr;
   logic [1:0]    gctr_wd, choice_wd, lctr_wd;
   logic [LB-1:0] lhist_wd;

   assign gmask = bdp_pkg::width_mask(gbits_ff, 5'(GB));
   assign lmask = LB'(bdp_pkg::width_mask(lbits_ff, 5'(LB)));
   assign amask = IB'(bdp_pkg::width_mask(abits_ff, 5'(IB)));

   assign pc       = req_tdata[31:0];
   assign ghist_m  = ghist_ff & gmask;
   assign gidx_acc = (mode_ff == bdp_pkg::MODE_GSHARE) ? ((pc[GB-1:0] ^ ghist_m) & gmask)
                                                       : ghist_m;
   assign aidx_acc = pc[IB-1:0] & amask;

   assign req_tready = (state_ff == bdp_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign clearing   = (state_ff == bdp_pkg::ST_CLEAR);
   assign commit     = (state_ff == bdp_pkg::ST_CTR) && (!rsp_valid_ff || rsp_tready);
   assign lidx_hist  = lhist_rd & lmask;

   assign gpred = gctr_rd[1];
   assign lpred = lctr_rd[1];

   always_comb begin
      unique case (mode_ff)
         bdp_pkg::MODE_STATIC:     pred = 1'b1;
         bdp_pkg::MODE_GSHARE:     pred = gpred;
         bdp_pkg::MODE_TOURNAMENT: pred = choice_rd[1] ? gpred : lpred;
         bdp_pkg::MODE_NOT_TAKEN:  pred = 1'b0;
         default:                  pred = 1'b0;
      endcase
   end

   assign do_gs = commit && train_ff && (mode_ff == bdp_pkg::MODE_GSHARE);
   assign do_tn = commit && train_ff && (mode_ff == bdp_pkg::MODE_TOURNAMENT);

   // write ports: reset sweep or write-back
   always_comb begin
      if (clearing) begin
         gctr_we   = 1'b1;
         choice_we = 1'b1;
         lctr_we   = 1'b1;
         lhist_we  = 1'b1;
         g_waddr   = clr_ff;
         l_waddr   = clr_ff[LB-1:0];
         h_waddr   = clr_ff[IB-1:0];
         gctr_wd   = bdp_pkg::CTR_RESET;
         choice_wd = bdp_pkg::CHOICE_RESET;
         lctr_wd   = bdp_pkg::CTR_RESET;
         lhist_wd  = '0;
      end else begin
         gctr_we   = do_gs || do_tn;
         choice_we = do_tn && (gpred != lpred);
         lctr_we   = do_tn;
         lhist_we  = do_tn;
         g_waddr   = gidx_ff;
         l_waddr   = lidx_ff;
         h_waddr   = aidx_ff;
         gctr_wd   = bdp_pkg::count_toward(gctr_rd, outcome_ff);
         choice_wd = bdp_pkg::count_toward(choice_rd, gpred == outcome_ff);
         lctr_wd   = bdp_pkg::count_toward(lctr_rd, outcome_ff);
         lhist_wd  = {lidx_ff[LB-2:0], outcome_ff} & lmask;
      end
   end

   bdp_ram #(.WIDTH(2), .DEPTH(bdp_pkg::GLOBAL_DEPTH)) u_gctr (
      .clock (clock),
      .we    (gctr_we),
      .waddr (g_waddr),
      .wdata (gctr_wd),
      .re    (accept),
      .raddr (gidx_acc),
      .rdata (gctr_rd)
   );

   bdp_ram #(.WIDTH(2), .DEPTH(bdp_pkg::GLOBAL_DEPTH)) u_choice (
      .clock (clock),
      .we    (choice_we),
      .waddr (g_waddr),
      .wdata (choice_wd),
      .re    (accept),
      .raddr (gidx_acc),
      .rdata (choice_rd)
   );

   bdp_ram #(.WIDTH(LB), .DEPTH(bdp_pkg::INDEX_DEPTH)) u_lhist (
      .clock (clock),
      .we    (lhist_we),
      .waddr (h_waddr),
      .wdata (lhist_wd),
      .re    (accept),
      .raddr (aidx_acc),
      .rdata (lhist_rd)
   );

   bdp_ram #(.WIDTH(2), .DEPTH(bdp_pkg::LOCAL_DEPTH)) u_lctr (
      .clock (clock),
      .we    (lctr_we),
      .waddr (l_waddr),
      .wdata (lctr_wd),
      .re    (state_ff == bdp_pkg::ST_HIST),
      .raddr (lidx_hist),
      .rdata (lctr_rd)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ghist_in     = ghist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         bdp_pkg::ST_CLEAR: begin
            clr_in = clr_ff + GB'(1);
            if (clr_ff == GB'(bdp_pkg::GLOBAL_DEPTH - 1)) begin
               state_in = bdp_pkg::ST_IDLE;
            end
         end
         bdp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = bdp_pkg::ST_HIST;
            end
         end
         bdp_pkg::ST_HIST: begin
            state_in = bdp_pkg::ST_CTR;
         end
         bdp_pkg::ST_CTR: begin
            if (commit) begin
               state_in     = bdp_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (do_gs || do_tn) begin
                  ghist_in = {ghist_m[GB-2:0], outcome_ff} & gmask;
               end
            end
         end
         default: state_in = bdp_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         ghist_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ghist_ff     <= ghist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= bdp_pkg::MODE_GSHARE;
         gbits_ff <= 4'd13;
         lbits_ff <= 4'd11;
         abits_ff <= 4'd11;
      end else if (csr_we) begin
         unique case (bdp_pkg::csr_index_type'(csr_addr))
            bdp_pkg::CSR_MODE:        mode_ff  <= bdp_pkg::mode_type'(csr_wdata[1:0]);
            bdp_pkg::CSR_GLOBAL_BITS: gbits_ff <= csr_wdata;
            bdp_pkg::CSR_LOCAL_BITS:  lbits_ff <= csr_wdata;
            bdp_pkg::CSR_INDEX_BITS:  abits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gidx_ff    <= gidx_acc;
         aidx_ff    <= aidx_acc;
         train_ff   <= req_tuser;
         outcome_ff <= req_tdata[32];
      end
      if (state_ff == bdp_pkg::ST_HIST) begin
         lidx_ff <= lidx_hist;
      end
      if (commit) begin
         rsp_pred_ff <= pred;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_pred_ff};

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("request taken during memory sweep");

   a_accept_to_hist: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == bdp_pkg::ST_HIST))
      else $error("lookup did not start after request transfer");

   a_commit_to_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid)
      else $error("result lost at write-back");

   a_write_ctx: assert property (@(posedge clock) disable iff (reset)
      (gctr_we || lctr_we || lhist_we || choice_we) |-> (clearing || commit))
      else $error("memory written outside sweep or write-back");

endmodule

@@ rtl/bdp_ram.sv @@
module bdp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2048,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ test/branch_direction_predictor_core_tb.sv @@
module branch_direction_predictor_core_tb;

   localparam bit OP_PREDICT   = 1'b0;
   localparam bit OP_TRAIN     = 1'b1;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int TAIL_CYCLES  = 20;
   localparam int SITES        = 12;

   typedef struct {
      bit          op;
      logic [31:0] pc;
      bit          taken;
   } branch_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [31:0] branch_address, [32] taken_outcome
   logic        req_tuser = 1'b0; // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] predict_taken
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [3:0]  csr_wdata = '0;

   branch_type branch_queue[$];
   bit         expected_taken[$];
   int         queued_count = 0;
   int         accepted_count = 0;
   int         error_count = 0;
   int         cycle_count = 0;

   bit req_accepted = 1'b0;
   bit rsp_accepted = 1'b0;
   int req_gap = 0;
   int req_run = 0;
   int rsp_hold = 0;
   int rsp_run = 0;

   // predictor copy
   bdp_pkg::mode_type cfg_mode;
   logic [3:0]  cfg_gbits, cfg_lbits, cfg_abits;
   logic [1:0]  global_ctr [bdp_pkg::GLOBAL_DEPTH];
   logic [1:0]  choice_ctr [bdp_pkg::GLOBAL_DEPTH];
   logic [1:0]  local_ctr  [bdp_pkg::LOCAL_DEPTH];
   logic [10:0] local_hist [bdp_pkg::INDEX_DEPTH];
   logic [12:0] global_hist;

   branch_direction_predictor_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // zero counts as one bit, oversize clamps to the table width
   function automatic logic [12:0] hist_mask(logic [3:0] width, int limit);
      int n;
      n = (width == 4'd0) ? 1 : int'(width);
      if (n > limit) begin
         n = limit;
      end
      return 13'((1 << n) - 1);
   endfunction

   function automatic logic [1:0] nudge(logic [1:0] c, bit up);
      if (up) begin
         return (c == 2'd3) ? c : c + 2'd1;
      end
      return (c == 2'd0) ? c : c - 2'd1;
   endfunction

   function automatic bit predict_branch(bit op, logic [31:0] pc, bit taken);
      logic [12:0] gmask, ghist, gidx;
      logic [10:0] lmask, amask, aidx, lidx;
      bit          gvote, lvote, guess;
      bit          train;
      gmask = hist_mask(cfg_gbits, bdp_pkg::GLOBAL_BITS);
      lmask = 11'(hist_mask(cfg_lbits, bdp_pkg::LOCAL_BITS));
      amask = 11'(hist_mask(cfg_abits, bdp_pkg::INDEX_BITS));
      ghist = global_hist & gmask;
      train = (op == OP_TRAIN);
      guess = 1'b0;
      case (cfg_mode)
         bdp_pkg::MODE_STATIC: begin
            guess = 1'b1;
         end
         bdp_pkg::MODE_GSHARE: begin
            gidx  = (pc[12:0] ^ ghist) & gmask;
            guess = global_ctr[gidx] > 2'd1;
            if (train) begin
               global_ctr[gidx] = nudge(global_ctr[gidx], taken);
               global_hist      = {ghist[11:0], taken} & gmask;
            end
         end
         bdp_pkg::MODE_TOURNAMENT: begin
            aidx  = pc[10:0] & amask;
            lidx  = local_hist[aidx] & lmask;
            gvote = global_ctr[ghist] > 2'd1;
            lvote = local_ctr[lidx] > 2'd1;
            guess = (choice_ctr[ghist] < 2'd2) ? lvote : gvote;
            if (train) begin
               if (gvote == taken && lvote != taken) begin
                  choice_ctr[ghist] = nudge(choice_ctr[ghist], 1'b1);
               end else if (gvote != taken && lvote == taken) begin
                  choice_ctr[ghist] = nudge(choice_ctr[ghist], 1'b0);
               end
               global_ctr[ghist] = nudge(global_ctr[ghist], taken);
               local_ctr[lidx]   = nudge(local_ctr[lidx], taken);
               global_hist       = {ghist[11:0], taken} & gmask;
               local_hist[aidx]  = {lidx[9:0], taken} & lmask;
            end
         end
         default: begin
            guess = 1'b0;
         end
      endcase
      return guess;
   endfunction

   task automatic draw_wait(inout int run_left, output int cycles);
      if (run_left > 0) begin
         run_left--;
         cycles = 0;
      end else begin
         if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(10, 40);
         end
         cycles = $urandom_range(0, 14);
      end
   endtask

   task automatic queue_branch(bit op, logic [31:0] pc, bit taken);
      branch_type b;
      b.op    = op;
      b.pc    = pc;
      b.taken = taken;
      branch_queue.push_back(b);
      queued_count++;
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || expected_taken.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic program_regs(bdp_pkg::mode_type m, logic [3:0] gbits, logic [3:0] lbits,
                               logic [3:0] abits);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= bdp_pkg::CSR_MODE;
      csr_wdata <= {2'($urandom), m};
      @(negedge clock);
      csr_addr  <= bdp_pkg::CSR_GLOBAL_BITS;
      csr_wdata <= gbits;
      @(negedge clock);
      csr_addr  <= bdp_pkg::CSR_LOCAL_BITS;
      csr_wdata <= lbits;
      @(negedge clock);
      csr_addr  <= bdp_pkg::CSR_INDEX_BITS;
      csr_wdata <= abits;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly recurring branch sites with periodic outcomes, some noise
   task automatic queue_random_phase(int count);
      logic [31:0] site_pc      [SITES];
      logic [7:0]  site_pattern [SITES];
      int          site_period  [SITES];
      int          site_step    [SITES];
      int          s;
      bit          taken;
      bit          op;
      for (int i = 0; i < SITES; i++) begin
         site_pc[i]      = $urandom;
         site_pattern[i] = 8'($urandom);
         site_period[i]  = $urandom_range(1, 8);
         site_step[i]    = 0;
      end
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            s     = $urandom_range(0, SITES - 1);
            taken = site_pattern[s][site_step[s] % site_period[s]];
            if ($urandom_range(0, 9) == 0) begin
               taken = !taken;
            end
            op = ($urandom_range(0, 3) != 0) ? OP_TRAIN : OP_PREDICT;
            site_step[s]++;
            queue_branch(op, site_pc[s], taken);
         end else begin
            queue_branch($urandom_range(0, 1) ? OP_TRAIN : OP_PREDICT, $urandom,
                         $urandom_range(0, 1));
         end
      end
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      branch_type b;
      bit         v;
      if (!reset) begin
         v = req_tvalid;
         if (req_accepted) begin
            v            = 1'b0;
            req_accepted = 1'b0;
         end
         if (!v) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (branch_queue.size() > 0) begin
               b = branch_queue.pop_front();
               req_tuser <= b.op;
               req_tdata <= {7'b0, b.taken, b.pc};
               v = 1'b1;
               draw_wait(req_run, req_gap);
            end
         end
         req_tvalid <= v;
      end
   end

   // result sink
   always @(negedge clock) begin
      if (rsp_accepted) begin
         draw_wait(rsp_run, rsp_hold);
         rsp_accepted = 1'b0;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: config tracking, prediction on request transfer, check on result transfer
   always @(posedge clock) begin : monitor
      bit want;
      if (reset) begin
         cfg_mode    = bdp_pkg::MODE_GSHARE;
         cfg_gbits   = 4'd13;
         cfg_lbits   = 4'd11;
         cfg_abits   = 4'd11;
         global_hist = '0;
         for (int i = 0; i < bdp_pkg::GLOBAL_DEPTH; i++) begin
            global_ctr[i] = bdp_pkg::CTR_RESET;
            choice_ctr[i] = bdp_pkg::CHOICE_RESET;
         end
         for (int i = 0; i < bdp_pkg::LOCAL_DEPTH; i++) begin
            local_ctr[i] = bdp_pkg::CTR_RESET;
         end
         for (int i = 0; i < bdp_pkg::INDEX_DEPTH; i++) begin
            local_hist[i] = '0;
         end
      end else begin
         if (csr_we) begin
            case (bdp_pkg::csr_index_type'(csr_addr))
               bdp_pkg::CSR_MODE:        cfg_mode  = bdp_pkg::mode_type'(csr_wdata[1:0]);
               bdp_pkg::CSR_GLOBAL_BITS: cfg_gbits = csr_wdata;
               bdp_pkg::CSR_LOCAL_BITS:  cfg_lbits = csr_wdata;
               bdp_pkg::CSR_INDEX_BITS:  cfg_abits = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_accepted = 1'b1;
            if (expected_taken.size() == 0) begin
               $error("predict_taken: expected none, got %0b", rsp_tdata[0]);
               error_count++;
            end else begin
               want = expected_taken.pop_front();
               if (rsp_tdata[0] !== want) begin
                  $error("predict_taken: expected %0b, got %0b", want, rsp_tdata[0]);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_accepted = 1'b1;
            accepted_count++;
            expected_taken.push_back(predict_branch(req_tuser, req_tdata[31:0],
                                                    req_tdata[32]));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("branch_direction_predictor_core regression: fail");
      $finish;
   end

   initial begin
      bdp_pkg::mode_type m;
      logic [3:0] gb, lb, ab;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset settings: gshare, full widths
      queue_branch(OP_PREDICT, 32'h0000_0000, 1'b0);
      queue_branch(OP_TRAIN,   32'hFFFF_FFFF, 1'b1);
      queue_branch(OP_TRAIN,   32'hFFFF_FFFF, 1'b1);
      queue_branch(OP_TRAIN,   32'hFFFF_FFFF, 1'b1);
      queue_branch(OP_PREDICT, 32'hFFFF_FFFF, 1'b1);
      queue_branch(OP_TRAIN,   32'h0000_0000, 1'b0);
      queue_branch(OP_TRAIN,   32'h0000_0000, 1'b0);
      wait_drained();

      // static taken, zero widths; train is ignored
      program_regs(bdp_pkg::MODE_STATIC, 4'd0, 4'd0, 4'd0);
      queue_branch(OP_TRAIN,   32'h1234_5678, 1'b0);
      queue_branch(OP_PREDICT, 32'h0000_0000, 1'b0);
      wait_drained();

      program_regs(bdp_pkg::MODE_NOT_TAKEN, 4'd15, 4'd15, 4'd15);
      queue_branch(OP_PREDICT, 32'hFFFF_FFFF, 1'b1);
      queue_branch(OP_TRAIN,   32'h0000_0000, 1'b1);
      wait_drained();

      // tournament, oversize widths clamp; global and local disagree along the way
      program_regs(bdp_pkg::MODE_TOURNAMENT, 4'd15, 4'd15, 4'd15);
      queue_branch(OP_TRAIN,   32'hA5A5_0F0F, 1'b1);
      queue_branch(OP_TRAIN,   32'hA5A5_0F0F, 1'b1);
      queue_branch(OP_TRAIN,   32'hA5A5_0F0F, 1'b1);
      queue_branch(OP_TRAIN,   32'hA5A5_0F0F, 1'b1);
      queue_branch(OP_TRAIN,   32'hA5A5_0F0F, 1'b0);
      queue_branch(OP_PREDICT, 32'hA5A5_0F0F, 1'b0);
      queue_branch(OP_PREDICT, 32'h5A5A_F0F0, 1'b0);
      wait_drained();

      // width shrink with live history
      program_regs(bdp_pkg::MODE_TOURNAMENT, 4'd1, 4'd1, 4'd1);
      queue_branch(OP_TRAIN,   32'h0000_0001, 1'b1);
      queue_branch(OP_TRAIN,   32'h0000_0000, 1'b0);
      queue_branch(OP_TRAIN,   32'h0000_0001, 1'b1);
      queue_branch(OP_PREDICT, 32'h0000_0001, 1'b0);
      wait_drained();

      // back to gshare on shared state
      program_regs(bdp_pkg::MODE_GSHARE, 4'd0, 4'd0, 4'd0);
      queue_branch(OP_TRAIN,   32'hFFFF_FFFE, 1'b1);
      queue_branch(OP_PREDICT, 32'h0000_0001, 1'b0);
      wait_drained();

      for (int p = 0; p < 10; p++) begin
         case ($urandom_range(0, 9))
            0:       m = bdp_pkg::MODE_STATIC;
            1:       m = bdp_pkg::MODE_NOT_TAKEN;
            2, 3, 4: m = bdp_pkg::MODE_GSHARE;
            default: m = bdp_pkg::MODE_TOURNAMENT;
         endcase
         gb = 4'($urandom_range(0, 15));
         lb = 4'($urandom_range(0, 15));
         ab = 4'($urandom_range(0, 15));
         case (p)
            0: begin
               m  = bdp_pkg::MODE_TOURNAMENT;
               gb = 4'd13;
               lb = 4'd11;
               ab = 4'd11;
            end
            1: begin
               m  = bdp_pkg::MODE_TOURNAMENT;
               gb = 4'd1;
               lb = 4'd1;
               ab = 4'd1;
            end
            2: begin
               m  = bdp_pkg::MODE_GSHARE;
               gb = 4'd15;
               lb = 4'd0;
               ab = 4'd0;
            end
            default: ;
         endcase
         program_regs(m, gb, lb, ab);
         queue_random_phase($urandom_range(150, 250));
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_taken.size() == 0) begin
         $display("branch_direction_predictor_core regression: pass");
      end else begin
         $display("branch_direction_predictor_core regression: fail");
      end
      $finish;
   end

endmodule
